// ----- rtl/spinor_pkg.sv -----
// Shared types, command codes and constants for the SPI NOR flash command sequencer.
`timescale 1ns / 1ps

package spinor_pkg;

  localparam int PAGE_BYTES_DEF = 256;
  localparam int QDEPTH         = 4;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_PROGRAM = 3'd1,
    OP_READ    = 3'd2,
    OP_SAMPLE  = 3'd3,
    OP_ERASE   = 3'd4,
    OP_ID      = 3'd5,
    OP_STATUS  = 3'd6,
    OP_RX      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    KIND_SPI    = 3'd0,
    KIND_DATA   = 3'd1,
    KIND_WORD   = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_REJECT = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_P_WREN = 4'd1,
    PH_P_DATA = 4'd2,
    PH_P_WRDI = 4'd3,
    PH_POLL   = 4'd4,
    PH_E_WREN = 4'd5,
    PH_E_CMD  = 4'd6,
    PH_E_WRDI = 4'd7,
    PH_READ   = 4'd8,
    PH_SAMPLE = 4'd9,
    PH_ID     = 4'd10,
    PH_STATUS = 4'd11
  } phase_t;

  typedef enum logic [0:0] {
    CFG_MAKER_ID  = 1'b0,
    CFG_DEVICE_ID = 1'b1
  } cfg_index_t;

  localparam logic [7:0] CMD_WREN     = 8'h06;
  localparam logic [7:0] CMD_WRDI     = 8'h04;
  localparam logic [7:0] CMD_RDSR     = 8'h05;
  localparam logic [7:0] CMD_PP       = 8'h02;
  localparam logic [7:0] CMD_READ     = 8'h03;
  localparam logic [7:0] CMD_CHIP_ER  = 8'hC7;
  localparam logic [7:0] CMD_BLK64_ER = 8'hD8;
  localparam logic [7:0] CMD_BLK32_ER = 8'h52;
  localparam logic [7:0] CMD_SECT_ER  = 8'h20;
  localparam logic [7:0] CMD_JEDEC_ID = 8'h9F;
  localparam logic [7:0] DUMMY_BYTE   = 8'h00;

  localparam logic [7:0]  MAKER_ID_RST  = 8'hEF;
  localparam logic [15:0] DEVICE_ID_RST = 16'h4018;

  localparam logic [1:0] ERASE_SECT  = 2'd0;
  localparam logic [1:0] ERASE_BLK32 = 2'd1;
  localparam logic [1:0] ERASE_BLK64 = 2'd2;
  localparam logic [1:0] ERASE_CHIP  = 2'd3;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  mosi;
    logic        fend;
    logic [15:0] value;
    logic        last;
  } result_t;

  function automatic logic [7:0] erase_code(input logic [1:0] sz);
    logic [7:0] c;
    unique case (sz)
      ERASE_SECT:  c = CMD_SECT_ER;
      ERASE_BLK32: c = CMD_BLK32_ER;
      ERASE_BLK64: c = CMD_BLK64_ER;
      default:     c = CMD_CHIP_ER;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/spi_nor_flash_command_sequencer.sv -----
// Top level of the SPI NOR flash command sequencer: sequencing, page buffer and result queue.
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready  | tuser op; tdata page, erase_size, payload, rx
//  out_    | master    | out_tvalid / out_tready| tuser kind; tlast run_last; tdata mosi, fend, value
//  cfg_    | slave     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One input item per cycle while in_tready is high; results pass the result stage and the
//  result queue and leave one per cycle while out_tready is high. in_tready drops while the
//  result stage and the four-entry result queue hold more than two results. The page buffer
//  is a one-port-write, one-port-read RAM with registered read data, read at the transfer
//  that issues the byte; the result stage takes that data in.
//  The buffer needs no clearing pass. Reset is synchronous, active low; cfg_ready is always high.

module spi_nor_flash_command_sequencer #(
  parameter int PAGE_BYTES = spinor_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // page[15:0], erase_size[17:16], payload_byte[25:18],
                                  // rx_byte[33:26], zero[39:34]
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // mosi_byte[7:0], frame_end[8], host_value[24:9], zero[31:25]
  output logic [2:0]  out_tuser,  // kind[2:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int IW = $clog2(PAGE_BYTES + 5);
  localparam int QW = $clog2(spinor_pkg::QDEPTH);
  localparam int CW = QW + 1;

  localparam logic [IW-1:0] IDX_1 = IW'(1);
  localparam logic [IW-1:0] IDX_2 = IW'(2);
  localparam logic [IW-1:0] IDX_3 = IW'(3);
  localparam logic [IW-1:0] IDX_4 = IW'(4);
  localparam logic [IW-1:0] IDX_5 = IW'(5);
  localparam logic [IW-1:0] IDX_6 = IW'(6);

  // input unpack
  spinor_pkg::op_t op;
  logic [15:0] in_page;
  logic [1:0]  in_erase;
  logic [7:0]  in_payload;
  logic [7:0]  in_rx;
  logic        in_fire;

  assign op         = spinor_pkg::op_t'(in_tuser);
  assign in_page    = in_tdata[15:0];
  assign in_erase   = in_tdata[17:16];
  assign in_payload = in_tdata[25:18];
  assign in_rx      = in_tdata[33:26];
  assign in_fire    = in_tvalid && in_tready;

  // state
  spinor_pkg::phase_t phase_r, phase_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [15:0]   page_latch_r, page_latch_nxt;
  logic [1:0]    erase_latch_r, erase_latch_nxt;
  logic [7:0]    held_byte_r, held_byte_nxt;
  logic          id_match_r, id_match_nxt;
  logic [AW-1:0] load_index_r, load_index_nxt;
  logic [7:0]    maker_id_r;
  logic [15:0]   device_id_r;

  function automatic logic [IW-1:0] frame_len(input spinor_pkg::phase_t ph,
                                              input logic [1:0] es);
    logic [IW-1:0] n;
    unique case (ph)
      spinor_pkg::PH_P_DATA, spinor_pkg::PH_READ: n = IW'(PAGE_BYTES + 4);
      spinor_pkg::PH_POLL, spinor_pkg::PH_STATUS: n = IDX_2;
      spinor_pkg::PH_SAMPLE:                      n = IDX_6;
      spinor_pkg::PH_ID:                          n = IDX_4;
      spinor_pkg::PH_E_CMD:
        n = (es == spinor_pkg::ERASE_CHIP) ? IDX_1 : IDX_4;
      default:                                    n = IDX_1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] addr_byte(input logic [IW-1:0] i, input logic [15:0] pg);
    logic [7:0] b;
    if (i == IDX_1)      b = pg[15:8];
    else if (i == IDX_2) b = pg[7:0];
    else                 b = spinor_pkg::DUMMY_BYTE;
    return b;
  endfunction

  // frame byte for every position that does not come from the page buffer
  function automatic logic [7:0] frame_byte(input spinor_pkg::phase_t ph,
                                            input logic [IW-1:0] i,
                                            input logic [15:0] pg,
                                            input logic [1:0] es);
    logic [7:0] b;
    unique case (ph)
      spinor_pkg::PH_P_WREN, spinor_pkg::PH_E_WREN: b = spinor_pkg::CMD_WREN;
      spinor_pkg::PH_P_WRDI, spinor_pkg::PH_E_WRDI: b = spinor_pkg::CMD_WRDI;
      spinor_pkg::PH_POLL, spinor_pkg::PH_STATUS:
        b = (i == '0) ? spinor_pkg::CMD_RDSR : spinor_pkg::DUMMY_BYTE;
      spinor_pkg::PH_ID:
        b = (i == '0) ? spinor_pkg::CMD_JEDEC_ID : spinor_pkg::DUMMY_BYTE;
      spinor_pkg::PH_READ, spinor_pkg::PH_SAMPLE:
        b = (i == '0) ? spinor_pkg::CMD_READ : addr_byte(i, pg);
      spinor_pkg::PH_E_CMD:
        b = (i == '0) ? spinor_pkg::erase_code(es) : addr_byte(i, pg);
      spinor_pkg::PH_P_DATA: begin
        if (i == '0)         b = spinor_pkg::CMD_PP;
        else if (i < IDX_4)  b = addr_byte(i, pg);
        else if (i == IDX_4) b = pg[7:0];
        else if (i == IDX_5) b = pg[15:8];
        else                 b = spinor_pkg::DUMMY_BYTE;
      end
      default: b = spinor_pkg::DUMMY_BYTE;
    endcase
    return b;
  endfunction

  // sequencing
  logic              a_v;
  spinor_pkg::kind_t a_kind;
  logic [15:0]       a_value;
  logic              emit;
  logic              end_done;
  logic              fin;
  logic              mem_we;
  logic [IW-1:0]     idx_inc;

  always_comb begin
    phase_nxt       = phase_r;
    idx_nxt         = idx_r;
    page_latch_nxt  = page_latch_r;
    erase_latch_nxt = erase_latch_r;
    held_byte_nxt   = held_byte_r;
    id_match_nxt    = id_match_r;
    load_index_nxt  = load_index_r;
    a_v             = 1'b0;
    a_kind          = spinor_pkg::KIND_DONE;
    a_value         = '0;
    emit            = 1'b0;
    end_done        = 1'b0;
    fin             = 1'b0;
    mem_we          = 1'b0;
    idx_inc         = idx_r + IDX_1;
    if (op != spinor_pkg::OP_RX) begin
      if (phase_r != spinor_pkg::PH_IDLE) begin
        a_v    = 1'b1;
        a_kind = spinor_pkg::KIND_REJECT;
      end else if (op == spinor_pkg::OP_LOAD) begin
        mem_we         = 1'b1;
        load_index_nxt = (load_index_r == AW'(PAGE_BYTES - 1)) ? '0 : load_index_r + AW'(1);
        a_v            = 1'b1;
        a_kind         = spinor_pkg::KIND_DONE;
      end else begin
        page_latch_nxt  = in_page;
        erase_latch_nxt = in_erase;
        idx_nxt         = '0;
        emit            = 1'b1;
        unique case (op)
          spinor_pkg::OP_PROGRAM: begin
            phase_nxt      = spinor_pkg::PH_P_WREN;
            load_index_nxt = '0;
          end
          spinor_pkg::OP_READ:   phase_nxt = spinor_pkg::PH_READ;
          spinor_pkg::OP_SAMPLE: phase_nxt = spinor_pkg::PH_SAMPLE;
          spinor_pkg::OP_ERASE:  phase_nxt = spinor_pkg::PH_E_WREN;
          spinor_pkg::OP_ID:     phase_nxt = spinor_pkg::PH_ID;
          default:               phase_nxt = spinor_pkg::PH_STATUS;
        endcase
      end
    end else if (phase_r != spinor_pkg::PH_IDLE) begin
      unique case (phase_r)
        spinor_pkg::PH_READ: begin
          if (idx_r >= IDX_4) begin
            a_v     = 1'b1;
            a_kind  = spinor_pkg::KIND_DATA;
            a_value = {8'h00, in_rx};
          end
        end
        spinor_pkg::PH_SAMPLE: begin
          if (idx_r == IDX_4) begin
            held_byte_nxt = in_rx;
          end else if (idx_r == IDX_5) begin
            a_v     = 1'b1;
            a_kind  = spinor_pkg::KIND_WORD;
            a_value = {in_rx, held_byte_r};
            fin     = 1'b1;
          end
        end
        spinor_pkg::PH_ID: begin
          if (idx_r == IDX_1) begin
            id_match_nxt = (in_rx == maker_id_r);
          end else if (idx_r == IDX_2) begin
            id_match_nxt = id_match_r && (in_rx == device_id_r[15:8]);
          end else if (idx_r == IDX_3) begin
            a_v     = 1'b1;
            a_kind  = spinor_pkg::KIND_WORD;
            a_value = {15'd0, id_match_r && (in_rx == device_id_r[7:0])};
            fin     = 1'b1;
          end
        end
        spinor_pkg::PH_STATUS: begin
          if (idx_r == IDX_1) begin
            a_v     = 1'b1;
            a_kind  = spinor_pkg::KIND_WORD;
            a_value = {8'h00, in_rx};
            fin     = 1'b1;
          end
        end
        spinor_pkg::PH_POLL: begin
          if (idx_r == IDX_1 && !in_rx[0]) begin
            a_v    = 1'b1;
            a_kind = spinor_pkg::KIND_DONE;
            fin    = 1'b1;
          end
        end
        default: ;
      endcase
      if (!fin) begin
        if (idx_inc >= frame_len(phase_r, erase_latch_r)) begin
          idx_nxt = '0;
          unique case (phase_r)
            spinor_pkg::PH_P_WREN: phase_nxt = spinor_pkg::PH_P_DATA;
            spinor_pkg::PH_P_DATA: phase_nxt = spinor_pkg::PH_P_WRDI;
            spinor_pkg::PH_E_WREN: phase_nxt = spinor_pkg::PH_E_CMD;
            spinor_pkg::PH_E_CMD:  phase_nxt = spinor_pkg::PH_E_WRDI;
            spinor_pkg::PH_P_WRDI, spinor_pkg::PH_E_WRDI, spinor_pkg::PH_POLL:
              phase_nxt = spinor_pkg::PH_POLL;
            default: begin
              end_done = 1'b1;
              fin      = 1'b1;
            end
          endcase
        end else begin
          idx_nxt = idx_inc;
        end
      end
      if (fin) begin
        phase_nxt = spinor_pkg::PH_IDLE;
        idx_nxt   = '0;
      end else begin
        emit = 1'b1;
      end
    end
  end

  // transfer byte for the position after the update
  logic          mem_sel;
  logic [IW-1:0] buf_k;
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] idx_nxt_inc;
  logic          spi_fend;
  logic [7:0]    spi_byte;

  assign mem_sel     = (phase_nxt == spinor_pkg::PH_P_DATA) && (idx_nxt >= IDX_6);
  assign buf_k       = idx_nxt - IDX_4;
  assign rd_addr     = buf_k[AW-1:0];
  assign idx_nxt_inc = idx_nxt + IDX_1;
  assign spi_fend    = idx_nxt_inc >= frame_len(phase_nxt, erase_latch_nxt);
  assign spi_byte    = frame_byte(phase_nxt, idx_nxt, page_latch_nxt, erase_latch_nxt);

  spinor_pkg::result_t res_a, res_b, slot0, slot1;
  logic [1:0] slot_cnt;
  logic       b_v;

  assign b_v = emit || end_done;

  always_comb begin
    res_a.kind  = a_kind;
    res_a.mosi  = '0;
    res_a.fend  = 1'b0;
    res_a.value = a_value;
    res_a.last  = !b_v;
    res_b.kind  = emit ? spinor_pkg::KIND_SPI : spinor_pkg::KIND_DONE;
    res_b.mosi  = emit ? spi_byte : 8'h00;
    res_b.fend  = emit && spi_fend;
    res_b.value = '0;
    res_b.last  = 1'b1;
    slot0       = a_v ? res_a : res_b;
    slot1       = res_b;
    slot_cnt    = {1'b0, a_v} + {1'b0, b_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= spinor_pkg::PH_IDLE;
      idx_r         <= '0;
      page_latch_r  <= '0;
      erase_latch_r <= '0;
      held_byte_r   <= '0;
      id_match_r    <= 1'b0;
      load_index_r  <= '0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      idx_r         <= idx_nxt;
      page_latch_r  <= page_latch_nxt;
      erase_latch_r <= erase_latch_nxt;
      held_byte_r   <= held_byte_nxt;
      id_match_r    <= id_match_nxt;
      load_index_r  <= load_index_nxt;
    end
  end

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maker_id_r  <= spinor_pkg::MAKER_ID_RST;
      device_id_r <= spinor_pkg::DEVICE_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (spinor_pkg::cfg_index_t'(cfg_index) == spinor_pkg::CFG_MAKER_ID) begin
        maker_id_r <= cfg_data[7:0];
      end else begin
        device_id_r <= cfg_data;
      end
    end
  end

  // page buffer
  logic [7:0] buf_mem [PAGE_BYTES];
  logic [7:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (in_fire && mem_we) begin
      buf_mem[load_index_r] <= in_payload;
    end
    if (in_fire && emit && mem_sel) begin
      mem_rdata_r <= buf_mem[rd_addr];
    end
  end

  // result stage: takes in the registered buffer data
  spinor_pkg::result_t b_s0_r, b_s1_r, push0, push1;
  logic       b_m0_r, b_m1_r;
  logic [1:0] b_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_cnt_r <= '0;
    end else begin
      b_cnt_r <= in_fire ? slot_cnt : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_s0_r <= slot0;
      b_s1_r <= slot1;
      b_m0_r <= !a_v && emit && mem_sel;
      b_m1_r <= emit && mem_sel;
    end
  end

  always_comb begin
    push0 = b_s0_r;
    push1 = b_s1_r;
    if (b_m0_r) push0.mosi = mem_rdata_r;
    if (b_m1_r) push1.mosi = mem_rdata_r;
  end

  // result queue
  spinor_pkg::result_t q_mem_r [spinor_pkg::QDEPTH];
  spinor_pkg::result_t head;
  logic [QW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] q_cnt_r;
  logic          pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = q_cnt_r != '0;
  assign head       = q_mem_r[rd_ptr_r];
  assign in_tready  = ({1'b0, q_cnt_r} + (CW + 1)'(b_cnt_r)) <= (CW + 1)'(2);

  always_ff @(posedge clk) begin
    if (b_cnt_r != 2'd0) begin
      q_mem_r[wr_ptr_r] <= push0;
    end
    if (b_cnt_r == 2'd2) begin
      q_mem_r[wr_ptr_r + QW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QW'(b_cnt_r);
      rd_ptr_r <= rd_ptr_r + QW'(pop);
      q_cnt_r  <= q_cnt_r + CW'(b_cnt_r) - CW'(pop);
    end
  end

  assign out_tdata = {7'd0, head.value, head.fend, head.mosi};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

`ifndef SYNTHESIS
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, q_cnt_r} + (CW + 1)'(b_cnt_r)) <= (CW + 1)'(spinor_pkg::QDEPTH))
    else $error("result queue overflow");

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == spinor_pkg::PH_IDLE) |-> (idx_r == '0))
    else $error("byte index nonzero while idle");

  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op != spinor_pkg::OP_RX && phase_r != spinor_pkg::PH_IDLE)
      |=> ($stable(phase_r) && $stable(idx_r) && $stable(page_latch_r)))
    else $error("rejected request changed the sequence");

  a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(load_index_r) < PAGE_BYTES)
    else $error("load index out of range");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the SPI NOR flash command sequencer: directed and random requests.
`timescale 1ns / 1ps

module tb_top;

  localparam int PG = spinor_pkg::PAGE_BYTES_DEF;
  localparam logic [7:0] ERASE_OPC [4] = '{spinor_pkg::CMD_SECT_ER, spinor_pkg::CMD_BLK32_ER,
                                           spinor_pkg::CMD_BLK64_ER, spinor_pkg::CMD_CHIP_ER};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;  // page[15:0], erase_size[17:16], payload_byte[25:18],
                                 // rx_byte[33:26], zero[39:34]
  logic [2:0]  in_tuser   = '0;  // op[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // mosi_byte[7:0], frame_end[8], host_value[24:9], zero[31:25]
  logic [2:0]  out_tuser;        // kind[2:0]
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  // sequencer state as predicted
  spinor_pkg::phase_t ph   = spinor_pkg::PH_IDLE;
  int          bidx      = 0;
  int          ld_idx    = 0;
  logic [15:0] pg_l      = '0;
  logic [1:0]  er_l      = '0;
  logic [7:0]  held      = '0;
  logic        idm       = 1'b0;
  logic [7:0]  page_mem [256];
  logic [7:0]  maker_cfg = spinor_pkg::MAKER_ID_RST;
  logic [15:0] dev_cfg   = spinor_pkg::DEVICE_ID_RST;

  spinor_pkg::result_t due_results [$];
  int          items_sent     = 0;
  int          err_count      = 0;
  int          send_gap_pct   = 12;
  int          sink_stall_pct = 51;

  spi_nor_flash_command_sequencer #(.PAGE_BYTES(PG)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic int frame_len();
    case (ph)
      spinor_pkg::PH_P_DATA, spinor_pkg::PH_READ: return 4 + PG;
      spinor_pkg::PH_POLL, spinor_pkg::PH_STATUS: return 2;
      spinor_pkg::PH_SAMPLE:                      return 6;
      spinor_pkg::PH_ID:                          return 4;
      spinor_pkg::PH_E_CMD:  return (er_l == spinor_pkg::ERASE_CHIP) ? 1 : 4;
      default:                                    return 1;
    endcase
  endfunction

  function automatic logic [7:0] addr_byte(int idx);
    if (idx == 1) return pg_l[15:8];
    if (idx == 2) return pg_l[7:0];
    return spinor_pkg::DUMMY_BYTE;
  endfunction

  function automatic logic [7:0] tx_byte();
    int k;
    k = bidx - 4;
    case (ph)
      spinor_pkg::PH_P_WREN, spinor_pkg::PH_E_WREN: return spinor_pkg::CMD_WREN;
      spinor_pkg::PH_P_WRDI, spinor_pkg::PH_E_WRDI: return spinor_pkg::CMD_WRDI;
      spinor_pkg::PH_POLL, spinor_pkg::PH_STATUS:
        return (bidx == 0) ? spinor_pkg::CMD_RDSR : spinor_pkg::DUMMY_BYTE;
      spinor_pkg::PH_ID:
        return (bidx == 0) ? spinor_pkg::CMD_JEDEC_ID : spinor_pkg::DUMMY_BYTE;
      spinor_pkg::PH_READ, spinor_pkg::PH_SAMPLE: begin
        if (bidx == 0) return spinor_pkg::CMD_READ;
        return (bidx < 4) ? addr_byte(bidx) : spinor_pkg::DUMMY_BYTE;
      end
      spinor_pkg::PH_E_CMD: return (bidx == 0) ? ERASE_OPC[er_l] : addr_byte(bidx);
      spinor_pkg::PH_P_DATA: begin
        if (bidx == 0) return spinor_pkg::CMD_PP;
        if (bidx < 4) return addr_byte(bidx);
        // first two payload bytes carry the page number, low byte first
        if (k == 0) return pg_l[7:0];
        if (k == 1) return pg_l[15:8];
        return page_mem[k[7:0]];
      end
      default: return 8'h00;
    endcase
  endfunction

  function automatic void push_exp(spinor_pkg::kind_t kind, logic [7:0] mosi, logic fend,
                                   logic [15:0] value);
    spinor_pkg::result_t r;
    r.kind  = kind;
    r.mosi  = mosi;
    r.fend  = fend;
    r.value = value;
    r.last  = 1'b0;
    due_results.push_back(r);
  endfunction

  function automatic void push_spi();
    push_exp(spinor_pkg::KIND_SPI, tx_byte(), (bidx + 1 >= frame_len()), 16'h0000);
  endfunction

  function automatic void step_sequencer(spinor_pkg::op_t op, logic [15:0] page,
                                         logic [1:0] esz, logic [7:0] pay, logic [7:0] rx);
    int                  base;
    logic                done;
    spinor_pkg::result_t r;
    base = due_results.size();
    done = 1'b0;
    if (op != spinor_pkg::OP_RX) begin
      if (ph != spinor_pkg::PH_IDLE) begin
        push_exp(spinor_pkg::KIND_REJECT, 8'h00, 1'b0, 16'h0000);
      end else if (op == spinor_pkg::OP_LOAD) begin
        page_mem[ld_idx[7:0]] = pay;
        ld_idx = (ld_idx + 1) % PG;
        push_exp(spinor_pkg::KIND_DONE, 8'h00, 1'b0, 16'h0000);
      end else begin
        pg_l = page;
        er_l = esz;
        bidx = 0;
        case (op)
          spinor_pkg::OP_PROGRAM: begin
            ph = spinor_pkg::PH_P_WREN;
            ld_idx = 0;
          end
          spinor_pkg::OP_READ:   ph = spinor_pkg::PH_READ;
          spinor_pkg::OP_SAMPLE: ph = spinor_pkg::PH_SAMPLE;
          spinor_pkg::OP_ERASE:  ph = spinor_pkg::PH_E_WREN;
          spinor_pkg::OP_ID:     ph = spinor_pkg::PH_ID;
          default:               ph = spinor_pkg::PH_STATUS;
        endcase
        push_spi();
      end
    end else if (ph != spinor_pkg::PH_IDLE) begin
      case (ph)
        spinor_pkg::PH_READ:
          if (bidx >= 4) push_exp(spinor_pkg::KIND_DATA, 8'h00, 1'b0, {8'h00, rx});
        spinor_pkg::PH_SAMPLE: begin
          if (bidx == 4) held = rx;
          else if (bidx == 5) begin
            push_exp(spinor_pkg::KIND_WORD, 8'h00, 1'b0, {rx, held});
            done = 1'b1;
          end
        end
        spinor_pkg::PH_ID: begin
          if (bidx == 1) idm = (rx == maker_cfg);
          else if (bidx == 2) idm = idm & (rx == dev_cfg[15:8]);
          else if (bidx == 3) begin
            push_exp(spinor_pkg::KIND_WORD, 8'h00, 1'b0,
                     {15'h0000, idm & (rx == dev_cfg[7:0])});
            done = 1'b1;
          end
        end
        spinor_pkg::PH_STATUS: begin
          if (bidx == 1) begin
            push_exp(spinor_pkg::KIND_WORD, 8'h00, 1'b0, {8'h00, rx});
            done = 1'b1;
          end
        end
        spinor_pkg::PH_POLL: begin
          if (bidx == 1 && !rx[0]) begin
            push_exp(spinor_pkg::KIND_DONE, 8'h00, 1'b0, 16'h0000);
            done = 1'b1;
          end
        end
        default: ;
      endcase
      if (!done) begin
        bidx++;
        if (bidx >= frame_len()) begin
          bidx = 0;
          case (ph)
            spinor_pkg::PH_P_WREN: ph = spinor_pkg::PH_P_DATA;
            spinor_pkg::PH_P_DATA: ph = spinor_pkg::PH_P_WRDI;
            spinor_pkg::PH_E_WREN: ph = spinor_pkg::PH_E_CMD;
            spinor_pkg::PH_E_CMD:  ph = spinor_pkg::PH_E_WRDI;
            spinor_pkg::PH_P_WRDI, spinor_pkg::PH_E_WRDI, spinor_pkg::PH_POLL:
              ph = spinor_pkg::PH_POLL;
            default: begin
              push_exp(spinor_pkg::KIND_DONE, 8'h00, 1'b0, 16'h0000);
              done = 1'b1;
            end
          endcase
        end
      end
      if (done) begin
        ph = spinor_pkg::PH_IDLE;
        bidx = 0;
      end else begin
        push_spi();
      end
    end
    if (due_results.size() > base) begin
      r = due_results.pop_back();
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endfunction

  task automatic send_item(spinor_pkg::op_t op, logic [15:0] page, logic [1:0] esz,
                           logic [7:0] pay, logic [7:0] rx);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, rx, pay, esz, page};
    do @(posedge clk); while (!in_tready);
    if (!(op == spinor_pkg::OP_RX && ph == spinor_pkg::PH_IDLE)) items_sent++;
    step_sequencer(op, page, esz, pay, rx);
  endtask

  task automatic send_noise(spinor_pkg::op_t op);
    send_item(op, 16'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // id_miss: -1 random bytes, 0 all match, 1..3 corrupt that ID byte
  task automatic finish_sequence(int busy_polls, int id_miss, int reject_pct);
    logic [7:0] rx;
    int         polls;
    polls = busy_polls;
    while (ph != spinor_pkg::PH_IDLE) begin
      if ($urandom_range(0, 99) < reject_pct)
        send_noise(spinor_pkg::op_t'(3'($urandom_range(0, 6))));
      rx = 8'($urandom);
      if (ph == spinor_pkg::PH_POLL && bidx == 1) begin
        rx[0] = (polls > 0);
        if (polls > 0) polls--;
      end else if (ph == spinor_pkg::PH_ID && bidx > 0 && id_miss >= 0) begin
        case (bidx)
          1:       rx = maker_cfg;
          2:       rx = dev_cfg[15:8];
          default: rx = dev_cfg[7:0];
        endcase
        if (bidx == id_miss) rx = rx ^ 8'($urandom_range(1, 255));
      end
      send_item(spinor_pkg::OP_RX, 16'($urandom), 2'($urandom), 8'($urandom), rx);
    end
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (due_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (due_results.size() != 0) begin
      note_error($sformatf("%0d results never arrived", due_results.size()));
      due_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(spinor_pkg::cfg_index_t idx, logic [15:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == spinor_pkg::CFG_MAKER_ID) maker_cfg = value[7:0];
    else dev_cfg = value;
  endtask

  // every buffer entry is written before any program, then the load index wraps
  task automatic fill_page_buffer();
    for (int i = 0; i <= PG; i++)
      send_item(spinor_pkg::OP_LOAD, 16'($urandom), 2'($urandom),
                (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), 8'($urandom));
  endtask

  task automatic test_basic_requests();
    send_noise(spinor_pkg::OP_RX);
    send_item(spinor_pkg::OP_STATUS, 16'h0000, 2'd0, 8'h00, 8'h00);
    finish_sequence(0, -1, 0);
    send_item(spinor_pkg::OP_SAMPLE, 16'hFFFF, 2'd3, 8'hFF, 8'hFF);
    finish_sequence(0, -1, 0);
    send_item(spinor_pkg::OP_SAMPLE, 16'h0000, 2'd0, 8'h00, 8'h00);
    finish_sequence(0, -1, 0);
    for (int s = 0; s < 4; s++) begin
      send_item(spinor_pkg::OP_ERASE, s[0] ? 16'hFFFF : 16'h0000, 2'(s), 8'($urandom),
                8'($urandom));
      finish_sequence(s, -1, 0);
    end
    send_item(spinor_pkg::OP_READ, 16'h8001, 2'd1, 8'($urandom), 8'($urandom));
    finish_sequence(0, -1, 0);
    send_item(spinor_pkg::OP_PROGRAM, 16'hFFFF, 2'd2, 8'($urandom), 8'($urandom));
    finish_sequence(2, -1, 0);
    // every request kind is rejected while a status read runs
    send_item(spinor_pkg::OP_STATUS, 16'h1234, 2'd1, 8'($urandom), 8'($urandom));
    for (int o = 0; o < 7; o++) send_noise(spinor_pkg::op_t'(3'(o)));
    finish_sequence(0, -1, 0);
  endtask

  task automatic test_id_check();
    for (int m = 0; m < 4; m++) begin
      send_noise(spinor_pkg::OP_ID);
      finish_sequence(0, m, 0);
    end
    write_cfg(spinor_pkg::CFG_MAKER_ID, {8'($urandom), 8'h00});
    write_cfg(spinor_pkg::CFG_DEVICE_ID, 16'hFFFF);
    send_noise(spinor_pkg::OP_ID);
    finish_sequence(0, 0, 0);
    send_noise(spinor_pkg::OP_ID);
    finish_sequence(0, 1, 0);
    write_cfg(spinor_pkg::CFG_MAKER_ID, {8'($urandom), 8'hFF});
    write_cfg(spinor_pkg::CFG_DEVICE_ID, 16'h0000);
    send_noise(spinor_pkg::OP_ID);
    finish_sequence(0, 0, 0);
    send_noise(spinor_pkg::OP_ID);
    finish_sequence(0, 3, 0);
  endtask

  // short sequences only; full page programs and reads are covered above
  task automatic test_random_traffic();
    int goal;
    int pick;
    for (int seg = 0; seg < 3; seg++) begin
      send_gap_pct   = (seg == 0) ? 12 : (seg == 1) ? 51 : 0;
      sink_stall_pct = (seg == 0) ? 51 : (seg == 1) ? 12 : 0;
      write_cfg(spinor_pkg::CFG_MAKER_ID, 16'($urandom));
      write_cfg(spinor_pkg::CFG_DEVICE_ID, 16'($urandom));
      goal = items_sent + 40;
      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) send_noise(spinor_pkg::OP_LOAD);
        else if (pick < 50) send_noise(spinor_pkg::OP_RX);
        else send_noise(spinor_pkg::op_t'(3'($urandom_range(3, 6))));
        finish_sequence($urandom_range(0, 3), int'($urandom_range(0, 4)) - 1, 6);
      end
    end
  endtask

  always @(posedge clk) begin : result_sink
    spinor_pkg::result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        note_error($sformatf("unexpected result kind %0d data %h last %0d",
                             out_tuser, out_tdata, out_tlast));
      end else begin
        exp_r = due_results.pop_front();
        if (out_tuser != exp_r.kind || out_tdata[7:0] != exp_r.mosi ||
            out_tdata[8] != exp_r.fend || out_tdata[24:9] != exp_r.value ||
            out_tlast != exp_r.last)
          note_error($sformatf(
            "exp/act kind %0d/%0d mosi %02h/%02h fend %0d/%0d value %04h/%04h last %0d/%0d",
            exp_r.kind, out_tuser, exp_r.mosi, out_tdata[7:0], exp_r.fend, out_tdata[8],
            exp_r.value, out_tdata[24:9], exp_r.last, out_tlast));
      end
    end
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fill_page_buffer();
    test_basic_requests();
    test_id_check();
    test_random_traffic();
    drain_results();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/spinor_pkg.sv
rtl/spi_nor_flash_command_sequencer.sv
sim/tb_top.sv
